[hw/rtl/qph_pkg.sv]
// Shared types and codes of the quadratic probe hash table.
package qph_pkg;

    // Command codes.
    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_DELETE = 2'd3;

    // Slot tags.
    localparam logic [1:0] TAG_EMPTY   = 2'd0;
    localparam logic [1:0] TAG_LIVE    = 2'd1;
    localparam logic [1:0] TAG_DELETED = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_SLOT   = 2'd2;

    localparam int ACCOUNT_W   = 10;
    localparam int HEAD_W      = 48;
    localparam int TAIL_W      = 40;
    localparam int KEY_TERMS   = 21;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]         command;
        logic [19:0]        key_letters;
        logic [27:0]        key_digits_first;
        logic [39:0]        key_digits_second;
        logic signed [31:0] amount;
    } in_t;

    typedef struct packed {
        logic                 found;
        logic signed [31:0]   balance;
        logic [1:0]           status;
        logic [ACCOUNT_W-1:0] account_count;
    } out_t;

    // One classified command as it travels from front to back.
    typedef struct packed {
        logic [1:0]         cmd;
        logic [HEAD_W-1:0]  head;
        logic [TAIL_W-1:0]  tail;
        logic signed [31:0] amount;
    } job_t;

endpackage

[hw/rtl/qph_front.sv]
// Front end: accepts command words and computes the home slot of the key.
module qph_front import qph_pkg::*; #(
    parameter int TABLE_SIZE = 1019,
    localparam int IW = $clog2(TABLE_SIZE)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          enable,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_t           s_data,
    output logic          push,
    output job_t          push_job,
    output logic [IW-1:0] push_home,
    input  logic          full
);

    typedef logic [31:0][IW-1:0] pow_tab_t;
    typedef enum logic [1:0] {F_IDLE, F_SUM, F_PUSH} fstate_t;

    // Table of v^e mod TABLE_SIZE for every 5-bit character value.
    function automatic pow_tab_t make_tab(int e);
        pow_tab_t t;
        longint   z;
        longint   acc;
        for (int v = 0; v < 32; v++) begin
            z   = longint'(v) % TABLE_SIZE;
            acc = 1;
            for (int k = 0; k < e; k++) begin
                acc = (acc * z) % TABLE_SIZE;
            end
            t[v] = IW'(acc);
        end
        return t;
    endfunction

    fstate_t       state_reg, state_next;
    in_t           key_reg, key_next;
    logic [4:0]    pos_reg, pos_next;
    logic [IW-1:0] acc_reg, acc_next;
    logic [IW-1:0] term [KEY_TERMS];
    logic [IW:0]   sum;

    // One power lookup per key character; exponent 12 is skipped.
    for (genvar k = 0; k < KEY_TERMS; k++) begin : g_term
        localparam int       E   = (k < 11) ? k + 1 : k + 2;
        localparam pow_tab_t TAB = make_tab(E);
        logic [4:0] val;
        if (k < 4) begin : g_let
            assign val = key_reg.key_letters[5*k +: 5];
        end else if (k < 11) begin : g_df
            assign val = {1'b0, key_reg.key_digits_first[4*(k-4) +: 4]};
        end else begin : g_ds
            assign val = {1'b0, key_reg.key_digits_second[4*(k-11) +: 4]};
        end
        assign term[k] = TAB[val];
    end

    assign s_ready   = (state_reg == F_IDLE) && enable;
    assign push      = (state_reg == F_PUSH) && !full;
    assign push_home = acc_reg;
    assign push_job  = '{cmd: key_reg.command,
                         head: {key_reg.key_digits_first, key_reg.key_letters},
                         tail: key_reg.key_digits_second,
                         amount: key_reg.amount};

    // Add one term per cycle, reduced by a single conditional subtract.
    assign sum = {1'b0, acc_reg} + {1'b0, term[pos_reg]};

    always_comb begin
        state_next = state_reg;
        key_next   = key_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    key_next   = s_data;
                    pos_next   = '0;
                    acc_next   = '0;
                    state_next = F_SUM;
                end
            end
            F_SUM: begin
                acc_next = (sum >= (IW+1)'(TABLE_SIZE)) ? IW'(sum - (IW+1)'(TABLE_SIZE))
                                                        : IW'(sum);
                pos_next = pos_reg + 5'd1;
                if (pos_reg == 5'(KEY_TERMS - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (push) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        key_reg <= key_next;
        pos_reg <= pos_next;
        acc_reg <= acc_next;
    end

endmodule

[hw/rtl/qph_queue.sv]
// Short queue between the hashing front end and the probing back end.
module qph_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign full      = count_reg == (AW+1)'(DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = slot_reg[rd_ptr_reg];

    // Pointers wrap naturally since the depth is a power of two.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/qph_back.sv]
// Back end: walks the probe sequence over the slot memories and returns results.
module qph_back import qph_pkg::*; #(
    parameter int TABLE_SIZE = 1019,
    localparam int IW = $clog2(TABLE_SIZE),
    localparam int CW = $clog2(TABLE_SIZE + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    output logic          clearing,
    input  logic          job_valid,
    input  job_t          job,
    input  logic [IW-1:0] job_home,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output out_t          m_data
);

    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_READ, B_EVAL} bstate_t;

    localparam logic [IW:0] N_EXT = (IW+1)'(TABLE_SIZE);

    // Slot memories.
    logic [1:0]         tag_mem  [TABLE_SIZE];
    logic [HEAD_W-1:0]  head_mem [TABLE_SIZE];
    logic [TAIL_W-1:0]  tail_mem [TABLE_SIZE];
    logic signed [31:0] bal_mem  [TABLE_SIZE];

    logic [1:0]         tag_rd;
    logic [HEAD_W-1:0]  head_rd;
    logic [TAIL_W-1:0]  tail_rd;
    logic signed [31:0] bal_rd;

    bstate_t       state_reg, state_next;
    job_t          job_reg, job_next;
    logic [IW-1:0] home_reg, home_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] sq_reg, sq_next;
    logic [IW-1:0] d_reg, d_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          m_valid_reg, m_valid_next;
    out_t          m_data_reg, m_data_next;

    logic          rd_en;
    logic [IW-1:0] probe_slot;
    logic [IW:0]   probe_sum, sq_sum, d_sum;
    logic [IW-1:0] probe_add;
    logic          tag_we, key_we, bal_we;
    logic [1:0]    tag_wd;
    logic [IW-1:0] wr_addr;
    logic          match, last, out_free;
    logic          done, fill, update, remove, absent;
    logic [32:0]   add_sum;
    logic signed [31:0] sat_bal;
    logic signed [31:0] res_bal;
    logic          res_found;
    logic [1:0]    res_status;

    assign clearing = state_reg == B_CLEAR;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign pop      = (state_reg == B_IDLE) && job_valid;
    assign out_free = !m_valid_reg || m_ready;

    // Probe address: home plus i squared for even i, minus it for odd i.
    assign probe_add  = (i_reg[0] && sq_reg != '0) ? IW'(N_EXT - {1'b0, sq_reg}) : sq_reg;
    assign probe_sum  = {1'b0, home_reg} + {1'b0, probe_add};
    assign probe_slot = (probe_sum >= N_EXT) ? IW'(probe_sum - N_EXT) : IW'(probe_sum);
    assign rd_en      = state_reg == B_READ;

    // Next square and next odd step, both kept below the table size.
    assign sq_sum = {1'b0, sq_reg} + {1'b0, d_reg};
    assign d_sum  = {1'b0, d_reg} + (IW+1)'(2);

    // Memory ports: one write and one registered read each.
    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[wr_addr] <= tag_wd;
        end
        if (rd_en) begin
            tag_rd <= tag_mem[probe_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            head_mem[wr_addr] <= job_reg.head;
            tail_mem[wr_addr] <= job_reg.tail;
        end
        if (rd_en) begin
            head_rd <= head_mem[probe_slot];
            tail_rd <= tail_mem[probe_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (bal_we) begin
            bal_mem[wr_addr] <= res_bal;
        end
        if (rd_en) begin
            bal_rd <= bal_mem[probe_slot];
        end
    end

    // Saturating add of the amount to a stored balance.
    assign add_sum = {bal_rd[31], bal_rd} + {job_reg.amount[31], job_reg.amount};
    always_comb begin
        if (add_sum[32] != add_sum[31]) begin
            sat_bal = add_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_bal = add_sum[31:0];
        end
    end

    assign match = (tag_rd == TAG_LIVE) && (head_rd == job_reg.head) &&
                   (tail_rd == job_reg.tail);
    assign last  = i_reg == IW'(TABLE_SIZE - 1);

    // Classify the slot just read.
    always_comb begin
        fill   = 1'b0;
        update = 1'b0;
        remove = 1'b0;
        absent = 1'b0;
        case (job_reg.cmd)
            CMD_CREATE: begin
                fill = tag_rd != TAG_LIVE;
            end
            CMD_ADD: begin
                update = match;
                fill   = !match && (tag_rd == TAG_EMPTY);
            end
            default: begin
                absent = tag_rd == TAG_EMPTY;
                update = match && (job_reg.cmd == CMD_LOOKUP);
                remove = match && (job_reg.cmd == CMD_DELETE);
            end
        endcase
    end

    assign done = (state_reg == B_EVAL) && (fill || update || remove || absent || last);

    always_comb begin
        res_found  = 1'b0;
        res_bal    = -32'sd1;
        res_status = (job_reg.cmd == CMD_CREATE || job_reg.cmd == CMD_ADD) ? ST_NO_SLOT
                                                                         : ST_NOT_FOUND;
        if (fill) begin
            res_found  = 1'b1;
            res_bal    = job_reg.amount;
            res_status = ST_DONE;
        end else if (update) begin
            res_found  = 1'b1;
            res_bal    = (job_reg.cmd == CMD_ADD) ? sat_bal : bal_rd;
            res_status = ST_DONE;
        end else if (remove) begin
            res_found  = 1'b1;
            res_status = ST_DONE;
        end
    end

    // Write enables, gated so that nothing changes while the result waits.
    always_comb begin
        tag_we  = 1'b0;
        tag_wd  = TAG_EMPTY;
        key_we  = 1'b0;
        bal_we  = 1'b0;
        wr_addr = slot_reg;
        if (state_reg == B_CLEAR) begin
            tag_we  = 1'b1;
            wr_addr = clr_reg;
        end else if (done && out_free) begin
            if (fill) begin
                tag_we = 1'b1;
                tag_wd = TAG_LIVE;
                key_we = 1'b1;
                bal_we = 1'b1;
            end else if (remove) begin
                tag_we = 1'b1;
                tag_wd = TAG_DELETED;
            end else if (update && job_reg.cmd == CMD_ADD) begin
                bal_we = 1'b1;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        home_next    = home_reg;
        i_next       = i_reg;
        sq_next      = sq_reg;
        d_next       = d_reg;
        slot_next    = slot_reg;
        clr_next     = clr_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            B_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(TABLE_SIZE - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (pop) begin
                    job_next   = job;
                    home_next  = job_home;
                    i_next     = '0;
                    sq_next    = '0;
                    d_next     = IW'(1);
                    state_next = B_READ;
                end
            end
            B_READ: begin
                slot_next  = probe_slot;
                state_next = B_EVAL;
            end
            B_EVAL: begin
                if (done) begin
                    if (out_free) begin
                        if (fill) begin
                            count_next = count_reg + 1'b1;
                        end else if (remove && count_reg != '0) begin
                            count_next = count_reg - 1'b1;
                        end
                        m_valid_next = 1'b1;
                        m_data_next  = '{found: res_found, balance: res_bal,
                                         status: res_status,
                                         account_count: ACCOUNT_W'(count_next)};
                        state_next   = B_IDLE;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    sq_next    = (sq_sum >= N_EXT) ? IW'(sq_sum - N_EXT) : IW'(sq_sum);
                    d_next     = (d_sum >= N_EXT) ? IW'(d_sum - N_EXT) : IW'(d_sum);
                    state_next = B_READ;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        job_reg    <= job_next;
        home_reg   <= home_next;
        i_reg      <= i_next;
        sq_reg     <= sq_next;
        d_reg      <= d_next;
        slot_reg   <= slot_next;
        m_data_reg <= m_data_next;
    end

endmodule

[hw/rtl/quadratic_probe_hash_table_top.sv]
// Top level of the quadratic probe hash table.
//
// Input words (s_valid/s_ready, s_data) carry a command, a 21-character key
// and an amount. Each accepted word gives exactly one result word on
// m_valid/m_ready, m_data: found flag, balance, status and account count.
// The front end hashes the key one character per cycle and takes a new word
// only after it has pushed the last one into the queue. A two-entry queue
// feeds the back end, which takes a word in its idle state and then, for each
// probe, does a registered read of the slot memories followed by the compare
// and update. Throughput is set by the hash sum or by the probe walk,
// whichever is longer.
// After reset the back end sweeps the tag memory, and s_ready stays low until
// the sweep ends. The result waits in an output register while m_ready is
// low; the back end holds its slot until the result is taken, and the front
// end keeps hashing into the queue until the queue is full.
module quadratic_probe_hash_table_top import qph_pkg::*; #(
    parameter int TABLE_SIZE = 1019
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int QW = $bits(job_t) + IW;

    logic          clearing;
    logic          push, full, pop, not_empty;
    job_t          push_job, pop_job;
    logic [IW-1:0] push_home, pop_home;

    qph_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (!clearing),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_job  (push_job),
        .push_home (push_home),
        .full      (full)
    );

    qph_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_home, push_job}),
        .full      (full),
        .pop       (pop),
        .pop_data  ({pop_home, pop_job}),
        .not_empty (not_empty)
    );

    qph_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clearing  (clearing),
        .job_valid (not_empty),
        .job       (pop_job),
        .job_home  (pop_home),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[sim/quadratic_probe_hash_table_top_tb.sv]
// Self-checking testbench for the quadratic probe hash table top level.
`timescale 1ns / 100ps

module quadratic_probe_hash_table_top_tb;
    import qph_pkg::*;

    localparam int TS         = 1019;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 620;
    localparam int N_POOL     = 32;
    localparam int SLOW_STALL = 400;

    typedef struct {
        in_t  word;
        bit   typed;
        out_t res;
    } row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    quadratic_probe_hash_table_top #(.TABLE_SIZE(TS)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow copy of the table used to work out each answer.
    logic [1:0]  shadow_tag [TS];
    logic [47:0] shadow_head [TS];
    logic [39:0] shadow_tail [TS];
    int          shadow_bal [TS];
    int          shadow_live;

    out_t  pending_answers[$];
    row_t  directed[$];
    logic [19:0] pool_letters [N_POOL];
    logic [27:0] pool_first [N_POOL];
    logic [39:0] pool_second [N_POOL];

    int  n_sent;
    int  n_checked;
    int  n_errors;
    int  n_no_slot;
    int  n_absent;
    int  idle_cycles;
    bit  burst_mode;
    bit  hold_results;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Character value raised to a power, reduced modulo the table size.
    function automatic int unsigned char_power(int unsigned v, int unsigned e);
        int unsigned z;
        int unsigned acc;
        z = v % TS;
        acc = 1;
        if (z == 0) return 0;
        repeat (e) acc = (acc * z) % TS;
        return acc;
    endfunction

    function automatic int unsigned home_slot_of(in_t w);
        int unsigned sum;
        sum = 0;
        for (int p = 0; p < 4; p++)
            sum += char_power(32'((w.key_letters >> (5 * p)) & 20'h1F), p + 1);
        for (int p = 4; p < 11; p++)
            sum += char_power(32'((w.key_digits_first >> (4 * (p - 4))) & 28'hF), p + 1);
        for (int p = 12; p < 22; p++)
            sum += char_power(32'((w.key_digits_second >> (4 * (p - 12))) & 40'hF), p + 1);
        return sum % TS;
    endfunction

    function automatic out_t make_answer(bit f, int bal, logic [1:0] st);
        out_t r;
        r.found = f;
        r.balance = bal;
        r.status = st;
        r.account_count = shadow_live[ACCOUNT_W-1:0];
        return r;
    endfunction

    function automatic void place_entry(int s, logic [47:0] head, logic [39:0] tail, int amt);
        shadow_tag[s] = TAG_LIVE;
        shadow_head[s] = head;
        shadow_tail[s] = tail;
        shadow_bal[s] = amt;
        shadow_live++;
    endfunction

    // Apply one command to the shadow table and return its answer.
    function automatic out_t apply_command(in_t w);
        int unsigned home;
        int unsigned sq;
        int          s;
        logic [47:0] head;
        bit          hit;
        longint      sum;
        home = home_slot_of(w);
        head = {w.key_digits_first, w.key_letters};
        for (int i = 0; i < TS; i++) begin
            sq = (i * i) % TS;
            s = (i % 2 == 0) ? (home + sq) % TS : (home + TS - sq) % TS;
            hit = shadow_tag[s] == TAG_LIVE && shadow_head[s] == head
                  && shadow_tail[s] == w.key_digits_second;
            case (w.command)
                CMD_CREATE: begin
                    if (shadow_tag[s] != TAG_LIVE) begin
                        place_entry(s, head, w.key_digits_second, w.amount);
                        return make_answer(1'b1, w.amount, ST_DONE);
                    end
                end
                CMD_ADD: begin
                    if (hit) begin
                        sum = longint'(shadow_bal[s]) + longint'(w.amount);
                        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                        shadow_bal[s] = int'(sum);
                        return make_answer(1'b1, int'(sum), ST_DONE);
                    end
                    if (shadow_tag[s] == TAG_EMPTY) begin
                        place_entry(s, head, w.key_digits_second, w.amount);
                        return make_answer(1'b1, w.amount, ST_DONE);
                    end
                end
                default: begin
                    if (shadow_tag[s] == TAG_EMPTY) break;
                    if (hit) begin
                        if (w.command == CMD_LOOKUP)
                            return make_answer(1'b1, shadow_bal[s], ST_DONE);
                        shadow_tag[s] = TAG_DELETED;
                        shadow_bal[s] = -1;
                        if (shadow_live > 0) shadow_live--;
                        return make_answer(1'b1, -1, ST_DONE);
                    end
                end
            endcase
        end
        if (w.command == CMD_CREATE || w.command == CMD_ADD) begin
            n_no_slot++;
            return make_answer(1'b0, -1, ST_NO_SLOT);
        end
        n_absent++;
        return make_answer(1'b0, -1, ST_NOT_FOUND);
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [27:0] rand_bcd28();
        logic [27:0] v;
        for (int k = 0; k < 7; k++) v[4*k +: 4] = 4'($urandom_range(0, 9));
        return v;
    endfunction

    function automatic logic [39:0] rand_bcd40();
        logic [39:0] v;
        for (int k = 0; k < 10; k++) v[4*k +: 4] = 4'($urandom_range(0, 9));
        return v;
    endfunction

    function automatic logic [19:0] rand_letters();
        logic [19:0] v;
        for (int k = 0; k < 4; k++) v[5*k +: 5] = 5'($urandom_range(0, 25));
        return v;
    endfunction

    function automatic int rand_amount();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF - $urandom_range(0, 3);
            1: return -32'sh80000000 + $urandom_range(0, 3);
            2: return int'($urandom());
            default: return $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    // A key from the shared pool if from_pool is set, else a raw random one.
    function automatic in_t rand_word(bit from_pool);
        in_t w;
        int  k;
        int  r;
        r = $urandom_range(0, 99);
        w.command = r < 25 ? CMD_CREATE : r < 55 ? CMD_ADD : r < 82 ? CMD_LOOKUP : CMD_DELETE;
        if (from_pool) begin
            k = $urandom_range(0, N_POOL - 1);
            w.key_letters = pool_letters[k];
            w.key_digits_first = pool_first[k];
            w.key_digits_second = pool_second[k];
        end else begin
            w.key_letters = 20'($urandom());
            w.key_digits_first = 28'($urandom());
            w.key_digits_second = 40'({$urandom(), $urandom()});
        end
        w.amount = rand_amount();
        return w;
    endfunction

    // Offer one word, predict its answer on accept, then idle a while.
    task automatic send_word(in_t w, bit typed, out_t res);
        int   gap;
        out_t predicted;
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_command(w);
        pending_answers.insert(pending_answers.size(), typed ? res : predicted);
        n_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_answers.size() != 0);
    endtask

    task automatic add_row(logic [1:0] cmd, logic [19:0] l, logic [27:0] f, logic [39:0] d,
                           int amt, bit typed, bit fnd, int bal, logic [1:0] st, int cnt);
        row_t r;
        r.word.command = cmd;
        r.word.key_letters = l;
        r.word.key_digits_first = f;
        r.word.key_digits_second = d;
        r.word.amount = amt;
        r.typed = typed;
        r.res.found = fnd;
        r.res.balance = bal;
        r.res.status = st;
        r.res.account_count = ACCOUNT_W'(cnt);
        directed.insert(directed.size(), r);
    endtask

    // Receiver: random back-pressure, plus one long hold when asked.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_results && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (SLOW_STALL) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (burst_mode || $urandom_range(0, 99) < 60) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result word %p", $realtime, m_data);
                n_errors++;
            end else begin
                out_t want;
                want = pending_answers.pop_front();
                n_checked++;
                if (m_data.found !== want.found) begin
                    $display("%0t: found expected %0b actual %0b", $realtime,
                             want.found, m_data.found);
                    n_errors++;
                end
                if (m_data.balance !== want.balance) begin
                    $display("%0t: balance expected %0d actual %0d", $realtime,
                             want.balance, m_data.balance);
                    n_errors++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             want.status, m_data.status);
                    n_errors++;
                end
                if (m_data.account_count !== want.account_count) begin
                    $display("%0t: account_count expected %0d actual %0d", $realtime,
                             want.account_count, m_data.account_count);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence.
    initial begin
        bit   in_pool;
        out_t none;
        in_t  w;
        none = '0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        n_no_slot = 0;
        n_absent = 0;
        burst_mode = 1'b0;
        hold_results = 1'b0;
        shadow_live = 0;
        for (int s = 0; s < TS; s++) begin
            shadow_tag[s] = TAG_EMPTY;
            shadow_bal[s] = 0;
        end
        for (int k = 0; k < N_POOL; k++) begin
            pool_letters[k] = (k % 8 == 7) ? 20'($urandom()) : rand_letters();
            pool_first[k] = (k % 8 == 6) ? 28'($urandom()) : rand_bcd28();
            pool_second[k] = (k % 8 == 5) ? 40'({$urandom(), $urandom()}) : rand_bcd40();
        end

        // Directed rows: zero key, all-ones key, a plain key, saturation, tombstones.
        add_row(CMD_LOOKUP, '0, '0, '0, 0, 1, 0, -1, ST_NOT_FOUND, 0);
        add_row(CMD_DELETE, '0, '0, '0, 0, 1, 0, -1, ST_NOT_FOUND, 0);
        add_row(CMD_CREATE, '0, '0, '0, 32'sh7FFFFFFF, 1, 1, 32'sh7FFFFFFF, ST_DONE, 1);
        add_row(CMD_ADD, '0, '0, '0, 1, 1, 1, 32'sh7FFFFFFF, ST_DONE, 1);
        add_row(CMD_ADD, '0, '0, '0, -32'sh80000000, 1, 1, -1, ST_DONE, 1);
        add_row(CMD_ADD, '0, '0, '0, -32'sh80000000, 1, 1, -32'sh80000000, ST_DONE, 1);
        add_row(CMD_LOOKUP, '0, '0, '0, 0, 1, 1, -32'sh80000000, ST_DONE, 1);
        add_row(CMD_DELETE, '0, '0, '0, 0, 1, 1, -1, ST_DONE, 0);
        add_row(CMD_LOOKUP, '0, '0, '0, 0, 1, 0, -1, ST_NOT_FOUND, 0);
        add_row(CMD_ADD, 20'h0A4C3, 28'h1234567, 40'h9876543210, 5, 1, 1, 5, ST_DONE, 1);
        add_row(CMD_CREATE, '1, '1, '1, -1, 1, 1, -1, ST_DONE, 2);
        add_row(CMD_LOOKUP, '1, '1, '1, 0, 1, 1, -1, ST_DONE, 2);
        add_row(CMD_CREATE, 20'h0A4C3, 28'h1234567, 40'h9876543210, 7, 1, 1, 7, ST_DONE, 3);
        add_row(CMD_LOOKUP, 20'h0A4C3, 28'h1234567, 40'h9876543210, 0, 0, 0, 0, 0, 0);
        add_row(CMD_DELETE, 20'h0A4C3, 28'h1234567, 40'h9876543210, 0, 1, 1, -1, ST_DONE, 2);
        add_row(CMD_LOOKUP, 20'h0A4C3, 28'h1234567, 40'h9876543210, 0, 0, 0, 0, 0, 0);
        add_row(CMD_CREATE, '0, '0, '0, -32'sh80000000, 1, 1, -32'sh80000000, ST_DONE, 3);
        add_row(CMD_ADD, '1, '1, '1, 32'sh7FFFFFFF, 1, 1, 32'sh7FFFFFFE, ST_DONE, 3);
        add_row(CMD_DELETE, '1, '1, '1, 0, 1, 1, -1, ST_DONE, 2);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[k]) send_word(directed[k].word, directed[k].typed, directed[k].res);

        // Random traffic mostly on pooled keys, with bursts and pressure points.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 60 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            if (n == 200) hold_results = 1'b1;
            if (n == 400) wait_drained();
            in_pool = ($urandom_range(0, 99) < 85);
            send_word(rand_word(in_pool), 1'b0, none);
        end
        burst_mode = 1'b0;
        wait_drained();

        // A raw key through every command, then reuse a tombstone.
        w = rand_word(1'b0);
        w.command = CMD_CREATE;
        send_word(w, 1'b0, none);
        w.command = CMD_ADD;
        send_word(w, 1'b0, none);
        w.command = CMD_LOOKUP;
        send_word(w, 1'b0, none);
        w.command = CMD_DELETE;
        send_word(w, 1'b0, none);
        w = directed[2].word;
        w.command = CMD_DELETE;
        send_word(w, 1'b0, none);
        w.command = CMD_CREATE;
        w.amount = 12345;
        send_word(w, 1'b0, none);
        w.command = CMD_LOOKUP;
        send_word(w, 1'b0, none);

        wait_drained();
        repeat (100) @(posedge aclk);

        $display("Sent %0d command words and checked %0d results, %0d live entries at the end.",
                 n_sent, n_checked, shadow_live);
        $display("Answers with no free slot: %0d, with key absent: %0d, mismatches: %0d.",
                 n_no_slot, n_absent, n_errors);
        if (n_errors == 0 && pending_answers.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[quadratic_probe_hash_table_top.f]
hw/rtl/qph_pkg.sv
hw/rtl/qph_front.sv
hw/rtl/qph_queue.sv
hw/rtl/qph_back.sv
hw/rtl/quadratic_probe_hash_table_top.sv
sim/quadratic_probe_hash_table_top_tb.sv
